/* rtl/binary_to_roman_numeral_assert.svh */
// Assertion macros used by the RTL datapath (b2r_dpath).
`ifndef BINARY_TO_ROMAN_NUMERAL_ASSERT_SVH
`define BINARY_TO_ROMAN_NUMERAL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B2R_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2R_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/b2r_pkg.sv */
`timescale 1ns / 1ps

package b2r_pkg;

    localparam int unsigned MaxValue = 3999;

    localparam logic [6:0] AsciiC = 7'd67;
    localparam logic [6:0] AsciiD = 7'd68;
    localparam logic [6:0] AsciiI = 7'd73;
    localparam logic [6:0] AsciiL = 7'd76;
    localparam logic [6:0] AsciiM = 7'd77;
    localparam logic [6:0] AsciiV = 7'd86;
    localparam logic [6:0] AsciiX = 7'd88;

    typedef logic [3:0] uaddr_t;

    localparam uaddr_t UA_LOAD  = 4'd0;
    localparam uaddr_t UA_DIGIT = 4'd1;
    localparam uaddr_t UA_NINE  = 4'd2;
    localparam uaddr_t UA_NINE2 = 4'd3;
    localparam uaddr_t UA_FOUR  = 4'd4;
    localparam uaddr_t UA_FOUR2 = 4'd5;
    localparam uaddr_t UA_FIVE  = 4'd6;
    localparam uaddr_t UA_REP   = 4'd7;
    localparam uaddr_t UA_NEXT  = 4'd8;
    localparam uaddr_t UA_FLUSH = 4'd9;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DIGIT,
        OP_EMIT,
        OP_REPEAT,
        OP_NEXT,
        OP_FLUSH
    } op_t;

    typedef enum logic [1:0] {
        SYM_NONE,
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } sym_sel_t;

    typedef enum logic [1:0] {
        BR_GOTO,
        BR_CLASS,
        BR_REP,
        BR_PLACE
    } br_t;

    typedef enum logic [1:0] {
        CLS_SMALL,
        CLS_FOUR,
        CLS_FIVE_UP,
        CLS_NINE
    } dclass_t;

    typedef struct packed {
        op_t      op;
        sym_sel_t sym;
        br_t      br;
        uaddr_t   target;
    } ucode_t;

    typedef struct packed {
        op_t      op;
        sym_sel_t sym;
    } ctrl_t;

    typedef struct packed {
        logic    hold;
        dclass_t cls;
        logic    rep_zero;
        logic    place_zero;
    } status_t;

    function automatic ucode_t ucode_rom(input uaddr_t addr);
        ucode_t w;
        case (addr)
            UA_LOAD:  w = '{OP_LOAD,   SYM_NONE, BR_GOTO,  UA_DIGIT};
            UA_DIGIT: w = '{OP_DIGIT,  SYM_NONE, BR_CLASS, UA_DIGIT};
            UA_NINE:  w = '{OP_EMIT,   SYM_ONE,  BR_GOTO,  UA_NINE2};
            UA_NINE2: w = '{OP_EMIT,   SYM_TEN,  BR_GOTO,  UA_NEXT};
            UA_FOUR:  w = '{OP_EMIT,   SYM_ONE,  BR_GOTO,  UA_FOUR2};
            UA_FOUR2: w = '{OP_EMIT,   SYM_FIVE, BR_GOTO,  UA_NEXT};
            UA_FIVE:  w = '{OP_EMIT,   SYM_FIVE, BR_GOTO,  UA_REP};
            UA_REP:   w = '{OP_REPEAT, SYM_ONE,  BR_REP,   UA_NEXT};
            UA_NEXT:  w = '{OP_NEXT,   SYM_NONE, BR_PLACE, UA_FLUSH};
            UA_FLUSH: w = '{OP_FLUSH,  SYM_NONE, BR_GOTO,  UA_LOAD};
            default:  w = '{OP_FLUSH,  SYM_NONE, BR_GOTO,  UA_LOAD};
        endcase
        return w;
    endfunction

    function automatic uaddr_t class_target(input dclass_t cls);
        uaddr_t a;
        case (cls)
            CLS_SMALL:   a = UA_REP;
            CLS_FOUR:    a = UA_FOUR;
            CLS_FIVE_UP: a = UA_FIVE;
            CLS_NINE:    a = UA_NINE;
            default:     a = UA_REP;
        endcase
        return a;
    endfunction

    function automatic logic [11:0] weight(input logic [1:0] place);
        logic [11:0] w;
        case (place)
            2'd0:    w = 12'd1;
            2'd1:    w = 12'd10;
            2'd2:    w = 12'd100;
            2'd3:    w = 12'd1000;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    function automatic logic [6:0] sym_one(input logic [1:0] place);
        logic [6:0] s;
        case (place)
            2'd0:    s = AsciiI;
            2'd1:    s = AsciiX;
            2'd2:    s = AsciiC;
            2'd3:    s = AsciiM;
            default: s = AsciiI;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] sym_five(input logic [1:0] place);
        logic [6:0] s;
        case (place)
            2'd0:    s = AsciiV;
            2'd1:    s = AsciiL;
            2'd2:    s = AsciiD;
            2'd3:    s = AsciiM;
            default: s = AsciiV;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] sym_ten(input logic [1:0] place);
        logic [6:0] s;
        case (place)
            2'd0:    s = AsciiX;
            2'd1:    s = AsciiC;
            2'd2:    s = AsciiM;
            2'd3:    s = AsciiM;
            default: s = AsciiX;
        endcase
        return s;
    endfunction

endpackage

/* rtl/b2r_useq.sv */
`timescale 1ns / 1ps

module b2r_useq (
    input  logic              aclk,
    input  logic              aresetn,
    input  b2r_pkg::status_t  status,
    output b2r_pkg::ctrl_t    ctrl
);

    b2r_pkg::uaddr_t upc_reg;
    b2r_pkg::uaddr_t upc_next;
    b2r_pkg::ucode_t uword;

    assign uword    = b2r_pkg::ucode_rom(upc_reg);
    assign ctrl.op  = uword.op;
    assign ctrl.sym = uword.sym;

    always_comb begin
        upc_next = upc_reg;
        if (!status.hold) begin
            case (uword.br)
                b2r_pkg::BR_GOTO:  upc_next = uword.target;
                b2r_pkg::BR_CLASS: upc_next = b2r_pkg::class_target(status.cls);
                b2r_pkg::BR_REP:   upc_next = status.rep_zero ? uword.target : upc_reg;
                b2r_pkg::BR_PLACE: upc_next = status.place_zero ? uword.target
                                                                : b2r_pkg::UA_DIGIT;
                default:           upc_next = b2r_pkg::UA_LOAD;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= b2r_pkg::UA_LOAD;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* rtl/b2r_dpath.sv */
`timescale 1ns / 1ps

`include "binary_to_roman_numeral_assert.svh"

module b2r_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  b2r_pkg::ctrl_t    ctrl,
    output b2r_pkg::status_t  status,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [11:0]       s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [6:0]        m_symbol,
    output logic              m_last
);

    logic [11:0] rem_reg,    rem_next;
    logic [1:0]  place_reg,  place_next;
    logic [1:0]  rep_reg,    rep_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [6:0]  pend_sym_reg,   pend_sym_next;
    logic        m_valid_reg,    m_valid_next;
    logic [6:0]  m_symbol_reg,   m_symbol_next;
    logic        m_last_reg,     m_last_next;

    logic [3:0]  digit;
    logic [11:0] digit_val;
    logic [6:0]  new_sym;
    logic        emit_req;
    logic        out_free;
    logic        hold;
    b2r_pkg::dclass_t cls;

    // digit of the current place: parallel compares against k * weight
    always_comb begin
        digit = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, rem_reg} >= 14'(b2r_pkg::weight(place_reg)) * 14'(k)) begin
                digit = 4'(k);
            end
        end
    end

    // digit * weight never exceeds the remainder, so 12 bits hold it
    assign digit_val = b2r_pkg::weight(place_reg) * {8'd0, digit};

    always_comb begin
        if (digit == 4'd9) begin
            cls = b2r_pkg::CLS_NINE;
        end else if (digit == 4'd4) begin
            cls = b2r_pkg::CLS_FOUR;
        end else if (digit >= 4'd5) begin
            cls = b2r_pkg::CLS_FIVE_UP;
        end else begin
            cls = b2r_pkg::CLS_SMALL;
        end
    end

    always_comb begin
        case (ctrl.sym)
            b2r_pkg::SYM_ONE:  new_sym = b2r_pkg::sym_one(place_reg);
            b2r_pkg::SYM_FIVE: new_sym = b2r_pkg::sym_five(place_reg);
            b2r_pkg::SYM_TEN:  new_sym = b2r_pkg::sym_ten(place_reg);
            default:           new_sym = b2r_pkg::sym_one(place_reg);
        endcase
    end

    assign emit_req = (ctrl.op == b2r_pkg::OP_EMIT) ||
                      ((ctrl.op == b2r_pkg::OP_REPEAT) && (rep_reg != 2'd0));
    assign out_free = !m_valid_reg || m_ready;
    // one symbol is held back so the final one can carry last
    assign hold = ((ctrl.op == b2r_pkg::OP_LOAD) && !s_valid) ||
                  ((emit_req || (ctrl.op == b2r_pkg::OP_FLUSH)) &&
                   pend_valid_reg && !out_free);

    assign status.hold       = hold;
    assign status.cls        = cls;
    assign status.rep_zero   = (rep_reg == 2'd0);
    assign status.place_zero = (place_reg == 2'd0);

    always_comb begin
        rem_next        = rem_reg;
        place_next      = place_reg;
        rep_next        = rep_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_symbol_next   = m_symbol_reg;
        m_last_next     = m_last_reg;
        if (!hold) begin
            case (ctrl.op)
                b2r_pkg::OP_LOAD: begin
                    rem_next        = (s_value > 12'(b2r_pkg::MaxValue)) ?
                                      12'(b2r_pkg::MaxValue) : s_value;
                    place_next      = 2'd3;
                    rep_next        = 2'd0;
                    pend_valid_next = 1'b0;
                end
                b2r_pkg::OP_DIGIT: begin
                    rem_next = rem_reg - digit_val;
                    if (digit >= 4'd5) begin
                        rep_next = 2'(digit - 4'd5);
                    end else begin
                        rep_next = digit[1:0];
                    end
                end
                b2r_pkg::OP_EMIT, b2r_pkg::OP_REPEAT: begin
                    if (emit_req) begin
                        if (pend_valid_reg) begin
                            m_valid_next  = 1'b1;
                            m_symbol_next = pend_sym_reg;
                            m_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = new_sym;
                        if (ctrl.op == b2r_pkg::OP_REPEAT) begin
                            rep_next = rep_reg - 2'd1;
                        end
                    end
                end
                b2r_pkg::OP_NEXT: begin
                    if (place_reg != 2'd0) begin
                        place_next = place_reg - 2'd1;
                    end
                end
                b2r_pkg::OP_FLUSH: begin
                    if (pend_valid_reg) begin
                        m_valid_next  = 1'b1;
                        m_symbol_next = pend_sym_reg;
                        m_last_next   = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                end
                default: begin
                    pend_valid_next = pend_valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg        <= 12'd0;
            place_reg      <= 2'd0;
            rep_reg        <= 2'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            rem_reg        <= rem_next;
            place_reg      <= place_next;
            rep_reg        <= rep_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_sym_reg <= pend_sym_next;
        m_symbol_reg <= m_symbol_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready  = (ctrl.op == b2r_pkg::OP_LOAD);
    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;

    `B2R_ASSERT_NOW(a_load_clean, aclk, aresetn,
        (ctrl.op == b2r_pkg::OP_LOAD), !pend_valid_reg, "symbol pending at load")
    `B2R_ASSERT_NXT(a_digit_fits, aclk, aresetn,
        (ctrl.op == b2r_pkg::OP_DIGIT),
        (rem_reg < b2r_pkg::weight($past(place_reg))), "remainder not reduced")
    `B2R_ASSERT_NXT(a_flush_done, aclk, aresetn,
        ((ctrl.op == b2r_pkg::OP_FLUSH) && !hold), !pend_valid_reg, "flush left symbol")

endmodule

/* rtl/binary_to_roman_numeral.sv */
`timescale 1ns / 1ps

// Binary to Roman numeral converter.
// Input beat (s_valid/s_ready, s_value): one unsigned value; 4000..4095 clamp to 3999.
// Output beats (m_valid/m_ready, m_symbol, m_last): the numeral's ASCII characters,
// thousands first, one per beat, m_last high on the final one. Zero yields no beat.
// A small microprogram steps through the four decimal places: a step to take
// a digit, a step per character, a step to leave each repeat loop and a step
// to advance the place, plus load and flush. The next value is taken only after
// the flush step.
// One character is held back so that the last one can be marked: the first
// character is presented once the second one is produced, and a single-character
// numeral waits for the flush.
// A stalled receiver backs up through the output register and halts the
// sequencer in place; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) returns the sequencer to the load step and
// clears the output valid; any partly emitted numeral is abandoned.

module binary_to_roman_numeral (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_symbol,
    output logic        m_last
);

    b2r_pkg::ctrl_t   ctrl;
    b2r_pkg::status_t status;

    b2r_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    b2r_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_symbol (m_symbol),
        .m_last   (m_last)
    );

endmodule
